### rtl/bgep_pkg.sv
// Package for the bit-granular entropy pool: stream field layout and the
// command and status groups between controller and datapath. No dependencies.
package bgep_pkg;

  localparam int WORD_BITS = 64;

  localparam int IN_W      = 208;
  localparam int REQ_LSB   = 0;
  localparam int REQ_W     = 8;
  localparam int SRC_A_LSB = 8;
  localparam int SRC_B_LSB = 72;
  localparam int SRC_C_LSB = 136;
  localparam int CNT_LSB   = 200;
  localparam int CNT_W     = 2;

  localparam int OUT_W       = 72;
  localparam int TAKEN_LSB   = 64;
  localparam int OUT_PAD_W   = OUT_W - WORD_BITS - CNT_W;

  typedef struct packed {
    logic load_req;
    logic fill;
    logic begin_emit;
    logic issue_rd;
    logic emit;
    logic clr_wr;
    logic fail_out;
  } cmd_t;

  typedef struct packed {
    logic req_zero;
    logic need_fill;
    logic src_empty;
    logic last_out;
    logic clr_done;
  } status_t;

endpackage

### rtl/bgep_ctrl.sv
// Controller for the bit-granular entropy pool: request sequencing state machine.
// Depends on bgep_pkg for the command and status groups.
module bgep_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic             out_free,
  input  bgep_pkg::status_t st,
  output bgep_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    IDLE,
    CHECK,
    READ,
    EMIT,
    CLR_RD,
    CLR_WR,
    FAIL
  } state_t;

  state_t state, state_next;

  assign s_tready = (state == IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      IDLE: begin
        if (s_tvalid) begin
          cmd.load_req = 1'b1;
          if (!st.req_zero) state_next = CHECK;
        end
      end
      CHECK: begin
        if (st.need_fill) begin
          if (st.src_empty) begin
            state_next = FAIL;
          end else begin
            cmd.fill = 1'b1;
          end
        end else begin
          cmd.begin_emit = 1'b1;
          state_next     = READ;
        end
      end
      READ: begin
        cmd.issue_rd = 1'b1;
        state_next   = EMIT;
      end
      EMIT: begin
        if (out_free) begin
          cmd.emit = 1'b1;
          if (!st.last_out) state_next = READ;
          else if (st.clr_done) state_next = IDLE;
          else state_next = CLR_RD;
        end
      end
      CLR_RD: begin
        cmd.issue_rd = 1'b1;
        state_next   = CLR_WR;
      end
      CLR_WR: begin
        cmd.clr_wr = 1'b1;
        state_next = st.clr_done ? IDLE : CLR_RD;
      end
      FAIL: begin
        if (out_free) begin
          cmd.fail_out = 1'b1;
          state_next   = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_load_needs_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.fail_out) |-> out_free)
    else $error("result loaded while output register is full");

endmodule

### rtl/bgep_datapath.sv
// Datapath for the bit-granular entropy pool: pool memory, index and count,
// fill, repack and clear logic. Depends on bgep_pkg.
module bgep_datapath #(
  parameter int POOL_WORDS        = 4,
  parameter int MAX_REQUEST_WORDS = 3
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [bgep_pkg::IN_W-1:0]  in_data,
  input  bgep_pkg::cmd_t             cmd,
  output bgep_pkg::status_t          st,
  output logic [63:0]                res_word,
  output logic                       res_last,
  output logic [1:0]                 res_taken
);

  localparam int PB       = POOL_WORDS * bgep_pkg::WORD_BITS;
  localparam int SIW      = $clog2(PB);
  localparam int WIW      = $clog2(POOL_WORDS);
  localparam int CW       = SIW + 1;
  localparam int CAP_A    = MAX_REQUEST_WORDS * bgep_pkg::WORD_BITS;
  localparam int CAP_B    = (POOL_WORDS - 1) * bgep_pkg::WORD_BITS;
  localparam int CAP_BITS = (CAP_A < CAP_B) ? CAP_A : CAP_B;
  localparam logic [CW-1:0] CAP = CW'(CAP_BITS);
  localparam logic [CW-1:0] PB_C = CW'(PB);
  localparam logic [63:0] ONES = '1;

  logic [63:0]    src_a, src_b, src_c;
  logic [1:0]     avail, taken;
  logic [7:0]     nbits;
  logic [SIW-1:0] start, vcount;
  logic [WIW-1:0] wp;
  logic [5:0]     rs, lo;
  logic [7:0]     left, out_left;

  logic [63:0]           mem [POOL_WORDS];
  logic [POOL_WORDS-1:0] vld;
  logic [63:0]           rd_a, rd_b;

  logic [7:0]     req_in, req_sat;
  logic [CW-1:0]  nbits_x, vcount_x, fill_sum, fill_pos, end_sum, end_pos;
  logic [WIW-1:0] fill_word, wp_inc;
  logic [63:0]    src_sel, shifted, out_mask, clr_mask, wr_data;
  logic [6:0]     span, cnt;
  logic           we;
  logic [WIW-1:0] wa;

  assign req_in  = in_data[bgep_pkg::REQ_LSB +: bgep_pkg::REQ_W];
  assign req_sat = ({{(CW-8){1'b0}}, req_in} > CAP) ? 8'(CAP) : req_in;

  assign nbits_x  = CW'(nbits);
  assign vcount_x = CW'(vcount);
  assign fill_sum = CW'(start) + vcount_x;
  assign fill_pos = (fill_sum >= PB_C) ? fill_sum - PB_C : fill_sum;
  assign fill_word = fill_pos[SIW-1:6];
  assign end_sum  = CW'(start) + nbits_x;
  assign end_pos  = (end_sum >= PB_C) ? end_sum - PB_C : end_sum;
  assign wp_inc   = (wp == WIW'(POOL_WORDS - 1)) ? '0 : wp + 1'b1;

  always_comb begin
    case (taken)
      2'd0:    src_sel = src_a;
      2'd1:    src_sel = src_b;
      default: src_sel = src_c;
    endcase
  end

  assign span = 7'd64 - {1'b0, lo};
  assign cnt  = (left < {1'b0, span}) ? left[6:0] : span;
  assign clr_mask = (cnt == 7'd0) ? '0 : ((ONES >> (7'd64 - cnt)) << lo);

  always_comb begin
    shifted = rd_a >> rs;
    if (rs != 6'd0) shifted = shifted | (rd_b << (7'd64 - {1'b0, rs}));
  end

  assign out_mask  = (out_left < 8'd64) ? (ONES >> (7'd64 - out_left[6:0])) : ONES;
  assign res_last  = (out_left <= 8'd64);
  assign res_word  = shifted & (res_last ? out_mask : ONES);
  assign res_taken = taken;

  assign st.req_zero  = (req_in == 8'd0);
  assign st.need_fill = (nbits_x > vcount_x);
  assign st.src_empty = (taken >= avail);
  assign st.last_out  = res_last;
  assign st.clr_done  = ({1'b0, cnt} >= left);

  assign we      = cmd.fill || cmd.emit || cmd.clr_wr;
  assign wa      = cmd.fill ? fill_word : wp;
  assign wr_data = cmd.fill ? src_sel : (rd_a & ~clr_mask);

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.issue_rd) begin
      rd_a <= vld[wp]     ? mem[wp]     : '0;
      rd_b <= vld[wp_inc] ? mem[wp_inc] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start  <= '0;
      vcount <= '0;
    end else if (cmd.fill) begin
      vcount <= vcount + SIW'(bgep_pkg::WORD_BITS);
    end else if (cmd.begin_emit) begin
      start  <= end_pos[SIW-1:0];
      vcount <= SIW'(vcount_x - nbits_x);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      src_a <= in_data[bgep_pkg::SRC_A_LSB +: bgep_pkg::WORD_BITS];
      src_b <= in_data[bgep_pkg::SRC_B_LSB +: bgep_pkg::WORD_BITS];
      src_c <= in_data[bgep_pkg::SRC_C_LSB +: bgep_pkg::WORD_BITS];
      avail <= in_data[bgep_pkg::CNT_LSB +: bgep_pkg::CNT_W];
      taken <= 2'd0;
      nbits <= req_sat;
    end else if (cmd.fill) begin
      taken <= taken + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.begin_emit) begin
      wp       <= start[SIW-1:6];
      rs       <= start[5:0];
      lo       <= start[5:0];
      left     <= nbits;
      out_left <= nbits;
    end else if (cmd.emit || cmd.clr_wr) begin
      wp       <= wp_inc;
      lo       <= 6'd0;
      left     <= left - 8'(cnt);
      out_left <= out_left - 8'd64;
    end
  end

  a_fill_has_src: assert property (@(posedge clk) disable iff (rst)
    cmd.fill |-> (taken < avail))
    else $error("pool fill without a valid source word");

  a_clear_has_bits: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.clr_wr) |-> (left != 8'd0))
    else $error("clear step with no used bits left");

  a_emit_covered: assert property (@(posedge clk) disable iff (rst)
    cmd.begin_emit |-> (nbits_x <= vcount_x))
    else $error("repack started with too few valid bits in the pool");

endmodule

### rtl/bit_granular_entropy_pool_core.sv
// Top level of the bit-granular entropy pool: stream ports and output register.
// Depends on bgep_pkg, bgep_ctrl and bgep_datapath.
//
//   channel   dir  tdata                                   tlast      tuser
//   s_*       in   request_bits, source_word_a/b/c, count  -          -
//   m_*       out  out_word, source_words_taken            last_word  success
//
// A request is loaded, then the pool takes one appended source word at a time, then
// each output word is read and emitted and each trailing clear word is read and
// written back via the single pool write port. A zero request gives no item. A
// failed request gives one item after the fills. A full output register holds the
// sequence before each output word. Reset clears pool valid bits, index and count at once.
module bit_granular_entropy_pool_core #(
  parameter int POOL_WORDS        = 4,
  parameter int MAX_REQUEST_WORDS = 3
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // request_bits[7:0], source_word_a[71:8], source_word_b[135:72],
  // source_word_c[199:136], source_valid_count[201:200], zero fill
  input  logic [bgep_pkg::IN_W-1:0]   s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // out_word[63:0], source_words_taken[65:64], zero fill
  output logic [bgep_pkg::OUT_W-1:0]  m_tdata,
  output logic                        m_tlast,
  // success[0]
  output logic                        m_tuser
);

  bgep_pkg::cmd_t    cmd;
  bgep_pkg::status_t st;
  logic              out_free;
  logic [63:0]       res_word;
  logic              res_last;
  logic [1:0]        res_taken;
  logic [63:0]       out_word;
  logic [1:0]        out_taken;

  assign out_free = !m_tvalid || m_tready;

  bgep_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .out_free (out_free),
    .st       (st),
    .cmd      (cmd)
  );

  bgep_datapath #(
    .POOL_WORDS        (POOL_WORDS),
    .MAX_REQUEST_WORDS (MAX_REQUEST_WORDS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .st        (st),
    .res_word  (res_word),
    .res_last  (res_last),
    .res_taken (res_taken)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit || cmd.fail_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_word  <= res_word;
      out_taken <= res_taken;
      m_tlast   <= res_last;
      m_tuser   <= 1'b1;
    end else if (cmd.fail_out) begin
      out_word  <= '0;
      out_taken <= res_taken;
      m_tlast   <= 1'b1;
      m_tuser   <= 1'b0;
    end
  end

  assign m_tdata = {{bgep_pkg::OUT_PAD_W{1'b0}}, out_taken, out_word};

endmodule
